// ===== src/free_list_heap_allocator_top_assert.svh =====
// Assertion macros used by the allocator datapath.
`ifndef FREE_LIST_HEAP_ALLOCATOR_TOP_ASSERT_SVH
`define FREE_LIST_HEAP_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FLHA_AST_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("flha same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define FLHA_AST_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("flha next-cycle check failed");

`endif

// ===== src/flha_pkg.sv =====
package flha_pkg;

  localparam int HEAP_UNITS = 65536;
  localparam int ADDR_W     = 16;
  localparam int HEAP_DEPTH = 1 << ADDR_W;
  localparam int UNIT_SHIFT = 3;  // 8-byte units

  localparam logic [16:0] HEAP_LIMIT_RST   = 17'd65536;
  localparam logic [16:0] GROW_UNITS       = 17'd4096;
  localparam logic [16:0] TOP_CAP          =
    (HEAP_UNITS < 65535) ? 17'(HEAP_UNITS) : 17'd65535;
  localparam logic [18:0] ALLOC_WALK_MAX   = 19'd262144;
  localparam logic [16:0] RELEASE_WALK_MAX = 17'd65536;

  localparam logic [1:0] ST_ALLOC = 2'd0;
  localparam logic [1:0] ST_OOM   = 2'd1;
  localparam logic [1:0] ST_REL   = 2'd2;
  localparam logic [1:0] ST_IGN   = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [18:0] request_bytes;
    logic [15:0] release_address;
  } flha_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] block_address;
  } flha_out_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH,
    S_A_START, S_A_NEXT, S_A_CHK, S_A_EXACT, S_A_TAIL, S_A_REGROW,
    S_I_START, S_I_WALK, S_I_B, S_I_C, S_I_D, S_I_E, S_I_F,
    S_REL_OK, S_DONE
  } flha_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_INIT,
    OP_RD_ROVER, OP_RD_ROVER_STEP, OP_TAKE_NEXT, OP_ADV,
    OP_RD_PREV, OP_UNLINK, OP_SPLIT, OP_TAIL, OP_GROW,
    OP_I_START, OP_I_ADV, OP_I_RDBP, OP_I_RDN, OP_I_WBP,
    OP_RD_BP, OP_I_RDP, OP_I_WP,
    OP_RES_OOM, OP_RES_IGN, OP_RES_REL, OP_PUSH
  } flha_op_t;

  typedef struct packed {
    logic kind_rel;
    logic rel_skip;
    logic fit;
    logic exact;
    logic p_is_rover;
    logic grow_ok;
    logic alloc_last;
    logic ins_stop;
    logic ins_last;
    logic out_free;
  } flha_stat_t;

endpackage

// ===== src/flha_ctrl.sv =====
module flha_ctrl import flha_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  flha_stat_t stat,
  output flha_op_t   op
);

  flha_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        if (!stat.kind_rel) state_nxt = S_A_START;
        else if (stat.rel_skip) state_nxt = S_DONE;
        else state_nxt = S_I_START;
      end
      S_A_START:  state_nxt = S_A_NEXT;
      S_A_REGROW: state_nxt = stat.alloc_last ? S_DONE : S_A_NEXT;
      S_A_NEXT:   state_nxt = S_A_CHK;
      S_A_CHK: begin
        priority if (stat.fit) state_nxt = stat.exact ? S_A_EXACT : S_A_TAIL;
        else if (stat.p_is_rover) state_nxt = stat.grow_ok ? S_I_START : S_DONE;
        else state_nxt = stat.alloc_last ? S_DONE : S_A_CHK;
      end
      S_A_EXACT:  state_nxt = S_DONE;
      S_A_TAIL:   state_nxt = S_DONE;
      S_I_START:  state_nxt = S_I_WALK;
      S_I_WALK: begin
        priority if (stat.ins_stop) state_nxt = S_I_B;
        else if (stat.ins_last) state_nxt = stat.kind_rel ? S_DONE : S_A_REGROW;
        else state_nxt = S_I_WALK;
      end
      S_I_B:      state_nxt = S_I_C;
      S_I_C:      state_nxt = S_I_D;
      S_I_D:      state_nxt = S_I_E;
      S_I_E:      state_nxt = S_I_F;
      S_I_F:      state_nxt = stat.kind_rel ? S_REL_OK : S_A_REGROW;
      S_REL_OK:   state_nxt = S_DONE;
      S_DONE:     if (stat.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    op       = OP_NONE;
    in_stall = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE:     if (in_valid) op = OP_LOAD;
      S_DISPATCH: begin
        if (!stat.kind_rel) op = OP_INIT;
        else if (stat.rel_skip) op = OP_RES_IGN;
        else op = OP_I_START;
      end
      S_A_START:  op = OP_RD_ROVER;
      S_A_REGROW: op = stat.alloc_last ? OP_RES_OOM : OP_RD_ROVER_STEP;
      S_A_NEXT:   op = OP_TAKE_NEXT;
      S_A_CHK: begin
        priority if (stat.fit) op = stat.exact ? OP_RD_PREV : OP_SPLIT;
        else if (stat.p_is_rover) op = stat.grow_ok ? OP_GROW : OP_RES_OOM;
        else op = stat.alloc_last ? OP_RES_OOM : OP_ADV;
      end
      S_A_EXACT:  op = OP_UNLINK;
      S_A_TAIL:   op = OP_TAIL;
      S_I_START:  op = OP_I_START;
      S_I_WALK: begin
        priority if (stat.ins_stop) op = OP_I_RDBP;
        else if (stat.ins_last) op = stat.kind_rel ? OP_RES_IGN : OP_NONE;
        else op = OP_I_ADV;
      end
      S_I_B:      op = OP_I_RDN;
      S_I_C:      op = OP_I_WBP;
      S_I_D:      op = OP_RD_BP;
      S_I_E:      op = OP_I_RDP;
      S_I_F:      op = OP_I_WP;
      S_REL_OK:   op = OP_RES_REL;
      S_DONE:     if (stat.out_free) op = OP_PUSH;
      default:    op = OP_NONE;
    endcase
  end

endmodule

// ===== src/flha_dp.sv =====
module flha_dp import flha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  flha_op_t    op,
  input  flha_in_t    in_data,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,
  input  logic        out_stall,
  output logic        out_valid,
  output flha_out_t   out_data,
  output flha_stat_t  stat
);

`include "free_list_heap_allocator_top_assert.svh"

  // header store: {size, next}
  logic [31:0] mem [HEAP_DEPTH];
  logic [31:0] rdata_r;

  logic [16:0] heap_limit_r, break_top_r, units_r;
  logic [15:0] rover_r, bp_r, p_r, prev_r, n_r, bsz_r;
  logic        ready_r, kind_r, rel_null_r, out_valid_r;
  logic [18:0] asteps_r;
  logic [16:0] isteps_r;
  flha_out_t   res_r, out_data_r;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [31:0]       wdata;

  logic [15:0] hsize, hnext, split_sz, newp;
  logic [16:0] top_lim, nu;
  logic [17:0] grow_sum;
  logic        merge_bp, merge_p;

  assign hsize    = rdata_r[31:16];
  assign hnext    = rdata_r[15:0];
  assign top_lim  = (heap_limit_r > TOP_CAP) ? TOP_CAP : heap_limit_r;
  assign nu       = (units_r < GROW_UNITS) ? GROW_UNITS : units_r;
  assign grow_sum = {1'b0, break_top_r} + {1'b0, nu};
  assign split_sz = hsize - units_r[15:0];
  assign newp     = p_r + split_sz;
  assign merge_bp = ({1'b0, bp_r} + {1'b0, bsz_r}) == {1'b0, n_r};
  assign merge_p  = ({1'b0, p_r} + {1'b0, hsize}) == {1'b0, bp_r};

  always_comb begin
    stat.kind_rel   = kind_r;
    stat.rel_skip   = rel_null_r || !ready_r;
    stat.fit        = {1'b0, hsize} >= units_r;
    stat.exact      = {1'b0, hsize} == units_r;
    stat.p_is_rover = (p_r == rover_r);
    stat.grow_ok    = grow_sum <= {1'b0, top_lim};
    stat.alloc_last = asteps_r >= ALLOC_WALK_MAX;
    stat.ins_stop   = (bp_r > p_r && bp_r < hnext) ||
                      (p_r >= hnext && (bp_r > p_r || bp_r < hnext));
    stat.ins_last   = isteps_r >= RELEASE_WALK_MAX;
    stat.out_free   = !out_valid_r || !out_stall;
  end

  // single-port memory sequencing
  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    waddr  = p_r;
    raddr  = p_r;
    wdata  = '0;
    unique case (op)
      OP_INIT: begin
        mem_we = !ready_r;
        waddr  = '0;
      end
      OP_RD_ROVER, OP_RD_ROVER_STEP, OP_I_START: begin
        mem_re = 1'b1;
        raddr  = rover_r;
      end
      OP_TAKE_NEXT, OP_ADV, OP_I_ADV: begin
        mem_re = 1'b1;
        raddr  = hnext;
      end
      OP_RD_PREV: begin
        mem_re = 1'b1;
        raddr  = prev_r;
      end
      OP_UNLINK: begin
        mem_we = 1'b1;
        waddr  = prev_r;
        wdata  = {hsize, n_r};
      end
      OP_SPLIT: begin
        mem_we = 1'b1;
        wdata  = {split_sz, hnext};
      end
      OP_TAIL: begin
        mem_we = 1'b1;
        wdata  = {units_r[15:0], 16'd0};
      end
      OP_GROW: begin
        mem_we = 1'b1;
        waddr  = break_top_r[ADDR_W-1:0];
        wdata  = {nu[15:0], 16'd0};
      end
      OP_I_RDBP, OP_RD_BP: begin
        mem_re = 1'b1;
        raddr  = bp_r;
      end
      OP_I_RDN: begin
        mem_re = 1'b1;
        raddr  = n_r;
      end
      OP_I_WBP: begin
        mem_we = 1'b1;
        waddr  = bp_r;
        wdata  = merge_bp ? {bsz_r + hsize, hnext} : {bsz_r, n_r};
      end
      OP_I_RDP: mem_re = 1'b1;
      OP_I_WP: begin
        mem_we = 1'b1;
        wdata  = merge_p ? {hsize + bsz_r, n_r} : {hsize, bp_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (mem_re) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_limit_r <= HEAP_LIMIT_RST;
      break_top_r  <= 17'd1;
      rover_r      <= '0;
      ready_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) heap_limit_r <= cfg_wdata;
      if (out_valid_r && !out_stall && op != OP_PUSH) out_valid_r <= 1'b0;
      unique case (op)
        OP_LOAD: begin
          kind_r     <= in_data.kind;
          units_r    <= {1'b0, in_data.request_bytes[18:UNIT_SHIFT]}
                        + {16'd0, |in_data.request_bytes[UNIT_SHIFT-1:0]} + 17'd1;
          bp_r       <= in_data.release_address - 16'd1;
          rel_null_r <= in_data.release_address <= 16'd1;
        end
        OP_INIT: begin
          if (!ready_r) rover_r <= '0;
          ready_r  <= 1'b1;
          asteps_r <= '0;
        end
        OP_RD_ROVER: prev_r <= rover_r;
        OP_RD_ROVER_STEP: begin
          prev_r   <= rover_r;
          asteps_r <= asteps_r + 19'd1;
        end
        OP_TAKE_NEXT: p_r <= hnext;
        OP_ADV: begin
          prev_r   <= p_r;
          p_r      <= hnext;
          asteps_r <= asteps_r + 19'd1;
        end
        OP_RD_PREV: n_r <= hnext;
        OP_UNLINK: begin
          rover_r <= prev_r;
          res_r   <= '{status: ST_ALLOC, block_address: p_r + 16'd1};
        end
        OP_SPLIT: begin
          p_r     <= newp;
          rover_r <= prev_r;
        end
        OP_TAIL: res_r <= '{status: ST_ALLOC, block_address: p_r + 16'd1};
        OP_GROW: begin
          break_top_r <= grow_sum[16:0];
          bp_r        <= break_top_r[15:0];
        end
        OP_I_START: begin
          p_r      <= rover_r;
          isteps_r <= '0;
        end
        OP_I_ADV: begin
          p_r      <= hnext;
          isteps_r <= isteps_r + 17'd1;
        end
        OP_I_RDBP: n_r <= hnext;
        OP_I_RDN: bsz_r <= hsize;
        OP_I_RDP: begin
          bsz_r <= hsize;
          n_r   <= hnext;
        end
        OP_I_WP: rover_r <= p_r;
        OP_RES_OOM: res_r <= '{status: ST_OOM, block_address: 16'd0};
        OP_RES_IGN: res_r <= '{status: ST_IGN, block_address: 16'd0};
        OP_RES_REL: res_r <= '{status: ST_REL, block_address: 16'd0};
        OP_PUSH: begin
          out_valid_r <= 1'b1;
          out_data_r  <= res_r;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `FLHA_AST_IMPL(a_port_excl, mem_we, !mem_re)
  `FLHA_AST_IMPL(a_top_cap, 1'b1, break_top_r <= TOP_CAP)
  `FLHA_AST_NEXT(a_ready_sticky, ready_r, ready_r)
  `FLHA_AST_NEXT(a_push_shows, op == OP_PUSH, out_valid_r)

endmodule

// ===== src/free_list_heap_allocator_top.sv =====
// Acceptance to out_valid: an allocate takes longer for each extra free-list header walked
//   and for each heap growth with its insert walk; a release takes longer for each header
//   walked; a null or ignored release is the shortest transaction.
// One transaction at a time: the next request is taken in the cycle after the result
//   is pushed.
// Reset: synchronous, active low; clears rover, list setup, heap top (1) and heap_limit
//   (65536). The header store is not cleared; it is written before it is read.
module free_list_heap_allocator_top import flha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  flha_in_t    in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output flha_out_t   out_data,
  // heap_limit register
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata
);

  // Controller sequences memory ops; datapath owns the header store,
  // list pointers and the result register.
  flha_op_t   op;
  flha_stat_t stat;

  flha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .op       (op)
  );

  // The result register lets a finished transaction wait for the sink
  // while the next request is taken.
  flha_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .stat      (stat)
  );

endmodule

// ===== bench/free_list_heap_allocator_top_tb.sv =====
`timescale 1ns / 1ps

module free_list_heap_allocator_top_tb;
  import flha_pkg::*;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int DRAIN_CYCLES   = 40;   // settle time after the last result
  localparam int PHASE_ITEMS    = 135;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  flha_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  flha_out_t out_data;
  logic        cfg_we;
  logic [16:0] cfg_wdata;

  free_list_heap_allocator_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Allocator shadow: headers {size[31:16], next[15:0]}, rover, heap top, limit
  // ---------------------------------------------------------------------------
  bit [31:0]   shadow_hdr [65536];
  int unsigned shadow_rover;
  int unsigned shadow_top;
  int unsigned shadow_limit;
  bit          shadow_ready;

  function automatic int unsigned hdr_nxt(int unsigned a);
    return shadow_hdr[a & 16'hFFFF][15:0];
  endfunction

  function automatic int unsigned hdr_sz(int unsigned a);
    return shadow_hdr[a & 16'hFFFF][31:16];
  endfunction

  function automatic void set_nxt(int unsigned a, int unsigned v);
    shadow_hdr[a & 16'hFFFF][15:0] = v[15:0];
  endfunction

  function automatic void set_sz(int unsigned a, int unsigned v);
    shadow_hdr[a & 16'hFFFF][31:16] = v[15:0];
  endfunction

  function automatic int unsigned heap_cap();
    int unsigned c;
    c = shadow_limit & 17'h1FFFF;
    if (c > HEAP_UNITS) c = HEAP_UNITS;
    if (c > 65535) c = 65535;
    return c;
  endfunction

  // Address-ordered insert with coalescing; 0 when the walk runs away.
  function automatic bit link_free_block(int unsigned bp);
    int unsigned p, n, steps;
    p = shadow_rover;
    steps = 0;
    forever begin
      n = hdr_nxt(p);
      if (bp > p && bp < n) break;
      if (p >= n && (bp > p || bp < n)) break;
      p = n;
      steps++;
      if (steps > RELEASE_WALK_MAX) return 1'b0;
    end
    n = hdr_nxt(p);
    if (bp + hdr_sz(bp) == n) begin
      set_sz(bp, hdr_sz(bp) + hdr_sz(n));
      set_nxt(bp, hdr_nxt(n));
    end else begin
      set_nxt(bp, n);
    end
    if (p + hdr_sz(p) == bp) begin
      set_sz(p, hdr_sz(p) + hdr_sz(bp));
      set_nxt(p, hdr_nxt(bp));
    end else begin
      set_nxt(p, bp);
    end
    shadow_rover = p & 16'hFFFF;
    return 1'b1;
  endfunction

  function automatic bit extend_heap(int unsigned units);
    int unsigned nu, hp;
    nu = (units < GROW_UNITS) ? GROW_UNITS : units;
    hp = shadow_top;
    if (hp + nu > heap_cap()) return 1'b0;
    set_sz(hp, nu);
    shadow_top = hp + nu;
    void'(link_free_block(hp));
    return 1'b1;
  endfunction

  // Next-fit search; returns data address or 0 when out of memory.
  function automatic int unsigned next_fit_alloc(int unsigned nbytes);
    int unsigned units, prev, p, sz, steps;
    units = (nbytes + 7) / 8 + 1;
    steps = 0;
    if (!shadow_ready) begin
      shadow_hdr[0] = '0;
      shadow_rover = 0;
      shadow_ready = 1'b1;
    end
    prev = shadow_rover;
    p = hdr_nxt(prev);
    forever begin
      sz = hdr_sz(p);
      if (sz >= units) begin
        if (sz == units) begin
          set_nxt(prev, hdr_nxt(p));
        end else begin
          set_sz(p, sz - units);
          p = (p + sz - units) & 16'hFFFF;
          set_sz(p, units);
        end
        shadow_rover = prev & 16'hFFFF;
        return (p + 1) & 16'hFFFF;
      end
      if (p == shadow_rover) begin
        if (!extend_heap(units)) return 0;
        p = shadow_rover;
      end
      prev = p;
      p = hdr_nxt(p);
      steps++;
      if (steps > ALLOC_WALK_MAX) return 0;
    end
  endfunction

  function automatic flha_out_t heap_step(flha_in_t req);
    flha_out_t r;
    int unsigned a;
    r.block_address = '0;
    if (req.kind == KIND_ALLOC) begin
      a = next_fit_alloc(32'(req.request_bytes));
      r.status = (a != 0) ? ST_ALLOC : ST_OOM;
      r.block_address = a[15:0];
    end else if (req.release_address <= 1 || !shadow_ready) begin
      r.status = ST_IGN;
    end else begin
      r.status = link_free_block(32'(req.release_address) - 32'd1) ? ST_REL : ST_IGN;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Bookkeeping
  // ---------------------------------------------------------------------------
  flha_out_t   pending_replies[$];
  int unsigned owned_blocks[$];   // data addresses currently held by the "user"
  int          errors;
  int          sender_idle_pct;
  int          stall_pct;
  int          quiet_cycles;
  int          n_alloc, n_oom, n_freed, n_ignored;

  // receiver back-pressure, changed on the falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // result transaction checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result status=%0d addr=%0d", $time,
                 out_data.status, out_data.block_address);
        errors++;
      end else begin
        if (out_data.status !== pending_replies[0].status) begin
          $display("%0t: status mismatch: expected %0d actual %0d", $time,
                   pending_replies[0].status, out_data.status);
          errors++;
        end
        if (out_data.block_address !== pending_replies[0].block_address) begin
          $display("%0t: block_address mismatch: expected %0d actual %0d", $time,
                   pending_replies[0].block_address, out_data.block_address);
          errors++;
        end
        void'(pending_replies.pop_front());
      end
      case (out_data.status)
        ST_ALLOC: n_alloc++;
        ST_OOM:   n_oom++;
        ST_REL:   n_freed++;
        default:  n_ignored++;
      endcase
    end
  end

  // watchdog: cycles without any transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 pending_replies.size());
        $display("free_list_heap_allocator_top regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Drives one request; on acceptance runs the shadow and queues the expectation.
  // If use_typed is set the hand-written expectation is queued instead.
  task automatic send_request(flha_in_t req, bit use_typed, flha_out_t typed);
    flha_out_t pred;
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = heap_step(req);
    if (req.kind == KIND_ALLOC && pred.status == ST_ALLOC)
      owned_blocks.push_back(32'(pred.block_address));
    pending_replies.push_back(use_typed ? typed : pred);
  endtask

  function automatic logic [15:0] take_owned_block();
    int idx;
    int unsigned a;
    if (owned_blocks.size() == 0) return 16'd0;
    idx = $urandom_range(0, owned_blocks.size() - 1);
    a = owned_blocks[idx];
    owned_blocks.delete(idx);
    return a[15:0];
  endfunction

  // lower valid, let every expected result arrive, then a settle time
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_heap_limit(logic [16:0] v);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    shadow_limit = 32'(v);
  endtask

  task automatic random_request(output flha_in_t req);
    int pick;
    int free_pct;
    req.kind            = KIND_ALLOC;
    req.request_bytes   = '0;
    req.release_address = '0;
    pick = $urandom_range(0, 99);
    free_pct = (owned_blocks.size() > 40) ? 70 : 35;
    if (pick < 5) begin
      // noise: null or sentinel release
      req.kind = KIND_FREE;
      req.release_address = 16'($urandom_range(0, 1));
    end else if (pick < 5 + free_pct && owned_blocks.size() != 0) begin
      req.kind = KIND_FREE;
      req.release_address = take_owned_block();
      req.request_bytes = 19'($urandom);   // don't-care field, still toggled
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      req.request_bytes = 19'($urandom_range(0, 200));
      else if (pick < 92) req.request_bytes = 19'($urandom_range(0, 40000));
      else                req.request_bytes = 19'($urandom);   // mostly out of memory
      req.release_address = 16'($urandom);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  typedef struct {
    logic        kind;
    logic [18:0] nbytes;
    logic [15:0] addr;
    bit          from_owned;  // release a block handed out earlier
    bit          typed;
    logic [1:0]  st;
    logic [15:0] ba;
  } dir_row_t;

  localparam int N_DIR = 22;
  dir_row_t dir_rows [N_DIR] = '{
    // releases before the list exists are ignored
    '{KIND_FREE,  19'd0,      16'hFFFF, 0, 1, ST_IGN,   16'd0},
    '{KIND_FREE,  19'd0,      16'd0,    0, 1, ST_IGN,   16'd0},
    // first allocate builds the list, grows one chunk, hands out its tail
    '{KIND_ALLOC, 19'd0,      16'd0,    0, 1, ST_ALLOC, 16'd4097},
    // sentinel and null releases
    '{KIND_FREE,  19'd0,      16'd1,    0, 1, ST_IGN,   16'd0},
    '{KIND_FREE,  19'd0,      16'd0,    0, 1, ST_IGN,   16'd0},
    // request that can never fit
    '{KIND_ALLOC, 19'h7FFFF,  16'd0,    0, 1, ST_OOM,   16'd0},
    '{KIND_ALLOC, 19'd1,      16'd0,    0, 0, ST_ALLOC, 16'd0},
    '{KIND_ALLOC, 19'd8,      16'd0,    0, 0, ST_ALLOC, 16'd0},
    '{KIND_ALLOC, 19'd9,      16'd0,    0, 0, ST_ALLOC, 16'd0},
    '{KIND_ALLOC, 19'd32767,  16'd0,    0, 0, ST_ALLOC, 16'd0},
    '{KIND_FREE,  19'd0,      16'd0,    1, 0, ST_REL,   16'd0},
    '{KIND_FREE,  19'd0,      16'd0,    1, 0, ST_REL,   16'd0},
    '{KIND_ALLOC, 19'd16,     16'd0,    0, 0, ST_ALLOC, 16'd0},
    '{KIND_ALLOC, 19'd100,    16'd0,    0, 0, ST_ALLOC, 16'd0},
    '{KIND_FREE,  19'd0,      16'd0,    1, 0, ST_REL,   16'd0},
    '{KIND_FREE,  19'd0,      16'd0,    1, 0, ST_REL,   16'd0},
    // big requests force growth past one chunk, then exhaust the heap
    '{KIND_ALLOC, 19'd262143, 16'd0,    0, 0, ST_ALLOC, 16'd0},
    '{KIND_ALLOC, 19'd262143, 16'd0,    0, 0, ST_ALLOC, 16'd0},
    '{KIND_FREE,  19'd0,      16'd0,    1, 0, ST_REL,   16'd0},
    '{KIND_FREE,  19'd0,      16'd0,    1, 0, ST_REL,   16'd0},
    '{KIND_ALLOC, 19'd7,      16'd0,    0, 0, ST_ALLOC, 16'd0},
    '{KIND_FREE,  19'd0,      16'd0,    1, 0, ST_REL,   16'd0}
  };

  // idling per phase: sender idle %, receiver stall %
  localparam int N_PHASES = 4;
  int idle_sched  [N_PHASES] = '{0, 71, 0, 32};
  int stall_sched [N_PHASES] = '{0, 0, 71, 32};
  // heap_limit per phase, extremes included (the top one is capped at 65535)
  logic [16:0] limit_sched [N_PHASES] = '{17'd1, 17'h1FFFF, 17'd20000, 17'd65536};

  initial begin
    flha_in_t  req;
    flha_out_t typed;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    errors = 0;
    quiet_cycles = 0;
    sender_idle_pct = 0;
    stall_pct = 0;
    n_alloc = 0; n_oom = 0; n_freed = 0; n_ignored = 0;
    shadow_rover = 0;
    shadow_top = 1;
    shadow_limit = 65536;
    shadow_ready = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part at full rate, reset heap_limit
    foreach (dir_rows[i]) begin
      req.kind = dir_rows[i].kind;
      req.request_bytes = dir_rows[i].nbytes;
      req.release_address = dir_rows[i].from_owned ? take_owned_block() : dir_rows[i].addr;
      typed.status = dir_rows[i].st;
      typed.block_address = dir_rows[i].ba;
      send_request(req, dir_rows[i].typed, typed);
    end

    // random phases; each limit change also makes the sender wait for all results
    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_heap_limit(limit_sched[ph]);
      sender_idle_pct = idle_sched[ph];
      stall_pct = stall_sched[ph];
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        random_request(req);
        send_request(req, 1'b0, typed);
      end
    end

    stall_pct = 0;
    drain();

    $display("covered: %0d allocations, %0d out-of-memory, %0d releases, %0d ignored",
             n_alloc, n_oom, n_freed, n_ignored);
    $display("heap_limit phases 1, 131071, 20000, 65536 under four idle/stall mixes");
    if (errors == 0) begin
      $display("free_list_heap_allocator_top regression: pass");
    end else begin
      $display("free_list_heap_allocator_top regression: fail");
    end
    $finish;
  end

endmodule
